// ----- src/bm_pkg.sv -----
// Package for the binary64 multiplier: field widths, special encodings and
// the leading-zero helper used to normalize subnormal operands.
// Used by bm_unpack and binary64_multiplier; depends on nothing.
package bm_pkg;

  localparam int FRAC_W  = 52;
  localparam int SIG_W   = 53;
  localparam int EXP_W   = 11;
  localparam int WORD_W  = 64;
  localparam int PROD_W  = 2 * SIG_W;
  localparam int XEXP_W  = 14;
  localparam int SHIFT_W = 7;
  localparam int LO_W    = 32;
  localparam int HI_W    = SIG_W - LO_W;
  localparam int STAGES  = 6;

  localparam logic [EXP_W-1:0]  EXP_ALL   = 11'h7FF;
  localparam logic [WORD_W-1:0] INF_BITS  = 64'h7FF0_0000_0000_0000;
  localparam logic [WORD_W-1:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic signed [XEXP_W-1:0] EXP_BIAS = 14'sd1023;
  localparam logic signed [XEXP_W-1:0] EXP_INF  = 14'sd2047;
  localparam logic signed [XEXP_W-1:0] FLUSH_D  = 14'sd53;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic signed [XEXP_W-1:0] xexp_t;

  // Left shift that brings the top set bit of a fraction up to the hidden bit
  function automatic logic [5:0] norm_shift(input logic [FRAC_W-1:0] f);
    logic [5:0] sh;
    sh = 6'(FRAC_W);
    for (int i = 0; i < FRAC_W; i++) begin
      if (f[i]) sh = 6'(FRAC_W - i);
    end
    return sh;
  endfunction

endpackage

// ----- src/bm_req_if.sv -----
// Request channel of the binary64 multiplier: two operands and result sign.
// Depends on nothing.
interface bm_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] x_bits;
  logic [63:0] y_bits;
  logic        result_negative;

  modport source (output valid, x_bits, y_bits, result_negative, input ready);
  modport sink   (input valid, x_bits, y_bits, result_negative, output ready);
endinterface

// ----- src/bm_rsp_if.sv -----
// Response channel of the binary64 multiplier: the rounded product.
// Depends on nothing.
interface bm_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] product_bits;

  modport source (output valid, product_bits, input ready);
  modport sink   (input valid, product_bits, output ready);
endinterface

// ----- src/bm_unpack.sv -----
// Operand unpack: hidden bit, subnormal normalization and the biased exponent.
// Depends on bm_pkg.
module bm_unpack (
  input  logic [bm_pkg::EXP_W-1:0]  exp_field,
  input  logic [bm_pkg::FRAC_W-1:0] frac,
  input  logic [5:0]                shift,
  output logic [bm_pkg::SIG_W-1:0]  sig,
  output bm_pkg::xexp_t             exp
);

  // Shift subnormals up to the hidden bit, otherwise insert it
  always_comb begin
    if (exp_field == '0) begin
      sig = bm_pkg::SIG_W'(frac) << shift;
      exp = bm_pkg::xexp_t'(1) - bm_pkg::xexp_t'(shift);
    end else begin
      sig = {1'b1, frac};
      exp = bm_pkg::xexp_t'(exp_field);
    end
  end

endmodule

// ----- src/binary64_multiplier.sv -----
// binary64 multiply, round to nearest even. Six register stages: a request
// passes through all of them before it is presented as a response, and one
// request is accepted per cycle while the response is not stalled. The whole
// pipeline advances whenever its last stage is empty or taken, so a stalled
// response holds every stage. Synchronous active-high reset clears the stage
// valid bits only.
module binary64_multiplier (
  input logic clk,
  input logic rst,
  bm_req_if.sink   req,
  bm_rsp_if.source rsp
);

  localparam int FW = bm_pkg::FRAC_W;
  localparam int SW = bm_pkg::SIG_W;
  localparam int PW = bm_pkg::PROD_W;
  localparam int LW = bm_pkg::LO_W;
  localparam int HW = bm_pkg::HI_W;

  logic [bm_pkg::STAGES-1:0] vld;
  logic                      adv;

  // Advance all stages together unless the response is stalled
  assign adv       = !vld[bm_pkg::STAGES-1] || rsp.ready;
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[bm_pkg::STAGES-2:0], req.valid};
    end
  end

  // Stage 1: classify operands, pick special results, find normalize shifts
  logic [10:0] xe_in, ye_in;
  logic [51:0] xf_in, yf_in;
  logic        xnan, ynan, xinf, yinf, xzero, yzero;
  logic        spec_in;
  bm_pkg::word_t spec_val_in, sign_w;

  always_comb begin
    xe_in  = req.x_bits[62:52];
    ye_in  = req.y_bits[62:52];
    xf_in  = req.x_bits[51:0];
    yf_in  = req.y_bits[51:0];
    sign_w = {req.result_negative, 63'd0};
    xnan   = (xe_in == bm_pkg::EXP_ALL) && (xf_in != '0);
    ynan   = (ye_in == bm_pkg::EXP_ALL) && (yf_in != '0);
    xinf   = (xe_in == bm_pkg::EXP_ALL) && (xf_in == '0);
    yinf   = (ye_in == bm_pkg::EXP_ALL) && (yf_in == '0);
    xzero  = (xe_in == '0) && (xf_in == '0);
    yzero  = (ye_in == '0) && (yf_in == '0);
    spec_in = 1'b1;
    if (xnan && ynan)        spec_val_in = sign_w | bm_pkg::INF_BITS | 64'(xf_in | yf_in);
    else if (xnan)           spec_val_in = req.x_bits;
    else if (ynan)           spec_val_in = req.y_bits;
    else if (xinf || yinf) begin
      if (xzero || yzero)    spec_val_in = bm_pkg::QNAN_BITS;
      else                   spec_val_in = sign_w | bm_pkg::INF_BITS;
    end else if (xzero || yzero) spec_val_in = sign_w;
    else begin
      spec_in     = 1'b0;
      spec_val_in = sign_w;
    end
  end

  logic [10:0] s1_xe, s1_ye;
  logic [51:0] s1_xf, s1_yf;
  logic [5:0]  s1_xsh, s1_ysh;
  logic        s1_sign, s1_spec;
  bm_pkg::word_t s1_spec_val;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_xe       <= xe_in;
      s1_ye       <= ye_in;
      s1_xf       <= xf_in;
      s1_yf       <= yf_in;
      s1_xsh      <= bm_pkg::norm_shift(xf_in);
      s1_ysh      <= bm_pkg::norm_shift(yf_in);
      s1_sign     <= req.result_negative;
      s1_spec     <= spec_in;
      s1_spec_val <= spec_val_in;
    end
  end

  // Stage 2: unpack both significands, add the exponents and subtract the bias
  logic [SW-1:0] a_sig, b_sig;
  bm_pkg::xexp_t a_exp, b_exp;

  bm_unpack u_unpack_x (.exp_field(s1_xe), .frac(s1_xf), .shift(s1_xsh),
                        .sig(a_sig), .exp(a_exp));
  bm_unpack u_unpack_y (.exp_field(s1_ye), .frac(s1_yf), .shift(s1_ysh),
                        .sig(b_sig), .exp(b_exp));

  logic [SW-1:0] s2_a, s2_b;
  bm_pkg::xexp_t s2_e;
  logic          s2_sign, s2_spec;
  bm_pkg::word_t s2_spec_val;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_a        <= a_sig;
      s2_b        <= b_sig;
      s2_e        <= a_exp + b_exp - bm_pkg::EXP_BIAS;
      s2_sign     <= s1_sign;
      s2_spec     <= s1_spec;
      s2_spec_val <= s1_spec_val;
    end
  end

  // Stage 3: four partial products of the split significands
  logic [2*LW-1:0]  s3_p00;
  logic [LW+HW-1:0] s3_p01, s3_p10;
  logic [2*HW-1:0]  s3_p11;
  bm_pkg::xexp_t    s3_e;
  logic             s3_sign, s3_spec;
  bm_pkg::word_t    s3_spec_val;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_p00      <= s2_a[LW-1:0] * s2_b[LW-1:0];
      s3_p01      <= s2_a[LW-1:0] * s2_b[SW-1:LW];
      s3_p10      <= s2_a[SW-1:LW] * s2_b[LW-1:0];
      s3_p11      <= s2_a[SW-1:LW] * s2_b[SW-1:LW];
      s3_e        <= s2_e;
      s3_sign     <= s2_sign;
      s3_spec     <= s2_spec;
      s3_spec_val <= s2_spec_val;
    end
  end

  // Stage 4: sum the partial products into the exact product
  logic [PW-1:0] s4_p;
  bm_pkg::xexp_t s4_e;
  logic          s4_sign, s4_spec;
  bm_pkg::word_t s4_spec_val;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_p        <= PW'(s3_p00) + (PW'(s3_p01) << LW) + (PW'(s3_p10) << LW)
                     + (PW'(s3_p11) << (2 * LW));
      s4_e        <= s3_e;
      s4_sign     <= s3_sign;
      s4_spec     <= s3_spec;
      s4_spec_val <= s3_spec_val;
    end
  end

  // Stage 5: normalize, detect overflow and flush, choose the right shift
  logic [PW-1:0] pn;
  bm_pkg::xexp_t e5, d5;
  logic          ovf, flush;
  bm_pkg::word_t sign5;

  always_comb begin
    pn    = s4_p[PW-1] ? s4_p : (s4_p << 1);
    e5    = s4_e + bm_pkg::xexp_t'(s4_p[PW-1]);
    ovf   = e5 >= bm_pkg::EXP_INF;
    d5    = (e5 >= 14'sd1) ? '0 : (14'sd1 - e5);
    flush = d5 > bm_pkg::FLUSH_D;
    sign5 = {s4_sign, 63'd0};
  end

  logic [PW-1:0]             s5_p;
  logic [10:0]               s5_e;
  logic                      s5_normal, s5_spec;
  logic [bm_pkg::SHIFT_W-1:0] s5_s;
  logic                      s5_sign;
  bm_pkg::word_t             s5_spec_val;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_p      <= pn;
      s5_e      <= e5[10:0];
      s5_normal <= e5 >= 14'sd1;
      s5_s      <= bm_pkg::SHIFT_W'(SW) + d5[bm_pkg::SHIFT_W-1:0];
      s5_sign   <= s4_sign;
      s5_spec   <= s4_spec || ovf || flush;
      if (s4_spec)  s5_spec_val <= s4_spec_val;
      else if (ovf) s5_spec_val <= sign5 | bm_pkg::INF_BITS;
      else          s5_spec_val <= sign5;
    end
  end

  // Stage 6: shift into place, round to nearest even, pack or pick the special result
  logic [PW-1:0]              shifted, below_mask;
  logic [bm_pkg::SHIFT_W-1:0] gpos;
  logic [63:0]                m, base, rounded;
  logic                       guard, sticky, rnd;

  always_comb begin
    shifted    = s5_p >> s5_s;
    m          = shifted[63:0];
    gpos       = s5_s - 7'd1;
    guard      = s5_p[gpos];
    below_mask = (PW'(1) << gpos) - PW'(1);
    sticky     = (s5_p & below_mask) != '0;
    rnd        = guard && (sticky || m[0]);
    base       = s5_normal ? {1'b0, s5_e, m[FW-1:0]} : m;
    rounded    = base + 64'(rnd);
  end

  logic [63:0] s6_prod;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_prod <= s5_spec ? s5_spec_val : ({s5_sign, 63'd0} | rounded);
    end
  end

  assign rsp.valid        = vld[bm_pkg::STAGES-1];
  assign rsp.product_bits = s6_prod;

endmodule

// ----- src/bm_checker.sv -----
// Port-level checks for binary64_multiplier, attached by bind.
// Depends on bm_req_if and bm_rsp_if through the bound top level.
module bm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] product
);

  // Hold a stalled response
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(product))
    else $error("stalled response changed");

  // Drop all responses after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("response valid right after reset");

  // Accept requests whenever the response slot is free or drained
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("request ready does not follow response stall");

  // Present a fully known product with every response
  a_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(product))
    else $error("response carries unknown bits");

endmodule

bind binary64_multiplier bm_checker u_bm_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (req.ready),
  .out_valid(rsp.valid),
  .out_ready(rsp.ready),
  .product  (rsp.product_bits)
);
